// ===== rtl/fpst_pkg.sv =====
// Package for the prefix-sum table: sizes, opcodes, beat structs and helpers.
// Used by fpst_store and fenwick_prefix_sum_table_core; depends on nothing.
package fpst_pkg;

  // Tree size and derived widths
  localparam int MAX_SIZE = 1024;
  localparam int ADDR_W   = $clog2(MAX_SIZE);  // node i lives at address i-1
  localparam int IDX_W    = ADDR_W + 2;        // walk index can reach 2*MAX_SIZE
  localparam int POS_W    = 11;
  localparam int VAL_W    = 32;
  localparam int SUM_W    = 48;
  localparam int OP_W     = 2;

  localparam logic [POS_W-1:0] SIZE_RESET = POS_W'(1024);
  localparam logic [POS_W-1:0] SIZE_MAX   = POS_W'(MAX_SIZE);

  // Opcodes
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Input beat
  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] add_value;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic signed [SUM_W-1:0] prefix_sum;
    logic                    out_of_range;
  } out_item_t;

  // Access request from the sequencer to the store
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SUM_W-1:0]  wr_data;
    logic              clr_start;
  } store_req_t;

  // Lowest set bit of a walk index
  function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] v);
    low_bit = v & (~v + IDX_W'(1));
  endfunction

endpackage

// ===== rtl/fenwick_prefix_sum_table_core.sv =====
// Binary indexed tree core. An add or query walks one tree node per cycle through the node
// RAM (read port plus registered data), then registers its result; the longest walk at 1024
// positions is an add at position 0, 11 nodes. A new beat is taken only back in idle, once
// the last result is registered. Empty queries walk no node; out-of-range beats and unused
// opcodes skip the walk. A clear, and the sweep after reset, zero the RAM one entry a cycle;
// no input beat meanwhile, and a clear's result follows the sweep. Config writes always taken.
module fenwick_prefix_sum_table_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fpst_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output fpst_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fpst_pkg::POS_W-1:0] cfg_data
);
  import fpst_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_CLR  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [POS_W-1:0]  size_r;
  logic [POS_W-1:0]  lim_r, lim_nxt;
  logic              is_add_r, is_add_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SUM_W-1:0]  val_r, val_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              oor_r, oor_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] paddr_r, paddr_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [POS_W-1:0]  eff_size;
  logic              in_fire;
  logic              issue;
  logic [IDX_W-1:0]  lb;
  store_req_t        sreq;
  logic [SUM_W-1:0]  rdata;
  logic              st_busy;

  fpst_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sreq),
    .rd_data (rdata),
    .busy    (st_busy)
  );

  // Size register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) size_r <= SIZE_RESET;
    else if (cfg_valid) size_r <= cfg_data;
  end

  assign eff_size = (size_r > SIZE_MAX) ? SIZE_MAX : size_r;
  assign in_ready = (state_r == ST_IDLE) && !st_busy;
  assign in_fire  = in_valid && in_ready;

  // Walk step: add climbs while inside the size, query descends to zero
  assign lb    = low_bit(idx_r);
  assign issue = is_add_r ? (idx_r <= IDX_W'(lim_r)) : (idx_r != '0);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    lim_nxt       = lim_r;
    is_add_nxt    = is_add_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    sum_nxt       = sum_r;
    oor_nxt       = oor_r;
    pend_nxt      = 1'b0;
    paddr_nxt     = paddr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    sreq          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          lim_nxt    = eff_size;
          is_add_nxt = (in_data.opcode == OP_ADD);
          idx_nxt    = IDX_W'(in_data.position);
          val_nxt    = {{(SUM_W-VAL_W){in_data.add_value[VAL_W-1]}}, in_data.add_value};
          sum_nxt    = '0;
          oor_nxt    = 1'b0;
          case (in_data.opcode)
            OP_ADD: begin
              if (in_data.position >= eff_size) begin
                oor_nxt   = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                idx_nxt   = IDX_W'(in_data.position) + IDX_W'(1);
                state_nxt = ST_WALK;
              end
            end
            OP_QUERY: begin
              if (in_data.position > eff_size) begin
                oor_nxt   = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_WALK;
              end
            end
            OP_CLEAR: begin
              sreq.clr_start = 1'b1;
              state_nxt      = ST_CLR;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_WALK: begin
        // read the next node while the previous one is folded in
        if (issue) begin
          sreq.rd_en   = 1'b1;
          sreq.rd_addr = ADDR_W'(idx_r - IDX_W'(1));
          idx_nxt      = is_add_r ? (idx_r + lb) : (idx_r - lb);
          pend_nxt     = 1'b1;
          paddr_nxt    = ADDR_W'(idx_r - IDX_W'(1));
        end
        if (pend_r) begin
          if (is_add_r) begin
            sreq.wr_en   = 1'b1;
            sreq.wr_addr = paddr_r;
            sreq.wr_data = rdata + val_r;
          end else begin
            sum_nxt = sum_r + rdata;
          end
        end
        if (!issue && !pend_r) state_nxt = ST_DONE;
      end
      ST_CLR: begin
        if (!st_busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.prefix_sum   = sum_r;
          out_nxt.out_of_range = oor_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lim_r    <= lim_nxt;
    is_add_r <= is_add_nxt;
    idx_r    <= idx_nxt;
    val_r    <= val_nxt;
    sum_r    <= sum_nxt;
    oor_r    <= oor_nxt;
    paddr_r  <= paddr_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Beats are only taken with the store free of its sweep
  a_accept_store_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> !st_busy)
    else $error("input beat taken during clearing sweep");

  // Write-back only happens inside a walk, in the cycle after its read
  a_wr_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    sreq.wr_en |-> (state_r == ST_WALK) && $past(sreq.rd_en))
    else $error("write-back outside a walk");

  // Read and write of one cycle never hit the same node, so no forwarding is needed
  a_no_same_node: assert property (@(posedge clk) disable iff (!rst_n)
    (sreq.wr_en && sreq.rd_en) |-> (sreq.wr_addr != sreq.rd_addr))
    else $error("read and write-back collide on one node");

endmodule

// ===== rtl/fpst_store.sv =====
// Node-sum store: one-write one-read synchronous RAM with a clearing sweep.
// Depends on fpst_pkg. The sweep runs after reset and on request.
module fpst_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fpst_pkg::store_req_t     req,
  output logic [fpst_pkg::SUM_W-1:0] rd_data,
  output logic                     busy
);
  import fpst_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_SIZE - 1);

  logic [SUM_W-1:0]  mem [MAX_SIZE];
  logic [SUM_W-1:0]  rd_data_r;
  logic              busy_r, busy_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              wen;
  logic [ADDR_W-1:0] waddr;
  logic [SUM_W-1:0]  wdata;

  // Sweep control
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (req.clr_start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + ADDR_W'(1);
      if (cnt_r == LAST_ADDR) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Write port: sweep has priority
  assign wen   = busy_r | req.wr_en;
  assign waddr = busy_r ? cnt_r : req.wr_addr;
  assign wdata = busy_r ? '0 : req.wr_data;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

  // The sequencer keeps off the RAM while the sweep owns the write port
  a_no_access_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !(req.rd_en || req.wr_en))
    else $error("store accessed during clearing sweep");

endmodule

// ===== dv/fenwick_prefix_sum_table_core_tb.sv =====
// Self-checking testbench for fenwick_prefix_sum_table_core: directed table, then random phases.
// Depends on fpst_pkg (beat structs, opcodes, sizes) and the core RTL only.
module fenwick_prefix_sum_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpst_pkg::*;

  // Opcode value that the block must answer without touching the tree
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [POS_W-1:0] cfg_data = '0;

  // Typed-in expectation travelling alongside the input beat
  logic pin_en = 1'b0;
  out_item_t pin_want = '0;

  // Mirror of the tree and its size register
  logic [SUM_W-1:0] node_sum [1:MAX_SIZE] = '{default: '0};
  logic [POS_W-1:0] size_reg = SIZE_RESET;
  out_item_t pending_results [$];
  int mismatch_count = 0;

  // Idling and hold-off controls
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // One row of the directed plan: either a size write or an input beat
  typedef struct {
    bit               is_cfg;
    logic [POS_W-1:0] cfg_val;
    in_item_t         beat;
    bit               pinned;
    out_item_t        want;
  } plan_row_t;
  plan_row_t plan [$];

  fenwick_prefix_sum_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Applies one beat to the mirrored tree and returns the result it gives
  function automatic out_item_t fenwick_apply(in_item_t b);
    out_item_t r;
    int n;
    int i;
    logic [SUM_W-1:0] delta;
    logic [SUM_W-1:0] acc;
    n = (size_reg > SIZE_MAX) ? MAX_SIZE : int'(size_reg);
    delta = {{(SUM_W-VAL_W){b.add_value[VAL_W-1]}}, b.add_value};
    acc = '0;
    r = '0;
    case (b.opcode)
      OP_ADD: begin
        if (int'(b.position) >= n) begin
          r.out_of_range = 1'b1;
        end else begin
          // walk upward, never past the size in use
          for (i = int'(b.position) + 1; i <= n; i += i & -i)
            node_sum[i] = node_sum[i] + delta;
        end
      end
      OP_QUERY: begin
        if (int'(b.position) > n) begin
          r.out_of_range = 1'b1;
        end else begin
          for (i = int'(b.position); i > 0; i -= i & -i)
            acc = acc + node_sum[i];
          r.prefix_sum = acc;
        end
      end
      OP_CLEAR: begin
        foreach (node_sum[k]) node_sum[k] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void report_fail(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] %s", $realtime, msg);
  endfunction

  function automatic void row_beat(logic [OP_W-1:0] op, int pos, logic [VAL_W-1:0] v,
                                   bit pin, longint s, bit oor);
    plan_row_t row;
    row = '{default: '0};
    row.beat.opcode = op;
    row.beat.position = POS_W'(pos);
    row.beat.add_value = v;
    row.pinned = pin;
    row.want.prefix_sum = SUM_W'(s);
    row.want.out_of_range = oor;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void row_cfg(int v);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_val = POS_W'(v);
    plan.insert(plan.size(), row);
  endfunction

  // Offers one input beat after random idling, returns at the accepting edge
  task automatic send_beat(in_item_t b, bit pin, out_item_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    pin_en   <= pin;
    pin_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lowers valid and waits until every due result has come back
  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_size(logic [POS_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Scoreboard: predict on accepted beats, compare accepted results in order
  always @(posedge clk) begin : scoreboard
    out_item_t guess;
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
      if (in_valid && in_ready) begin
        guess = fenwick_apply(in_data);
        pending_results.insert(pending_results.size(), pin_en ? pin_want : guess);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_fail($sformatf("result beat with nothing due: sum %0d oor %0b",
                                out_data.prefix_sum, out_data.out_of_range));
        end else begin
          want = pending_results.pop_front();
          if (out_data.prefix_sum !== want.prefix_sum)
            report_fail($sformatf("prefix_sum: expected %0d, got %0d",
                                  want.prefix_sum, out_data.prefix_sum));
          if (out_data.out_of_range !== want.out_of_range)
            report_fail($sformatf("out_of_range: expected %0b, got %0b",
                                  want.out_of_range, out_data.out_of_range));
        end
      end
    end
  end

  // Stimulus
  initial begin : stim
    int sizes [9];
    int ph;
    int k;
    int eff;
    int r;
    in_item_t b;
    logic [VAL_W-1:0] v;

    sizes = '{1024, 1, 2047, 5, 1000, 0, 64, 513, 1024};

    // Directed plan; store empty, size 1024 after reset
    row_beat(OP_QUERY, 0, '0, 1, 0, 0);
    row_beat(OP_QUERY, 1024, '0, 1, 0, 0);
    row_beat(OP_QUERY, 1025, '0, 1, 0, 1);
    row_beat(OP_ADD, 0, 32'h7FFF_FFFF, 1, 0, 0);
    row_beat(OP_ADD, 1023, 32'h8000_0000, 1, 0, 0);
    row_beat(OP_ADD, 1024, 32'd5, 1, 0, 1);
    row_beat(OP_ADD, 2047, 32'hFFFF_FFFF, 1, 0, 1);
    row_beat(OP_QUERY, 1, '0, 1, 2147483647, 0);
    row_beat(OP_QUERY, 1024, '0, 1, -1, 0);
    row_beat(OP_UNUSED, 2047, 32'hFFFF_FFFF, 1, 0, 0);
    row_beat(OP_ADD, 512, 32'd1000, 0, 0, 0);
    row_beat(OP_ADD, 511, -32'sd7, 0, 0, 0);
    row_beat(OP_QUERY, 513, '0, 0, 0, 0);
    row_beat(OP_CLEAR, 0, '0, 1, 0, 0);
    row_beat(OP_QUERY, 1024, '0, 1, 0, 0);
    row_beat(OP_ADD, 3, 32'd100, 0, 0, 0);
    row_beat(OP_ADD, 6, 32'd20, 0, 0, 0);
    // shrink with data held
    row_cfg(7);
    row_beat(OP_QUERY, 7, '0, 1, 120, 0);
    row_beat(OP_QUERY, 8, '0, 1, 0, 1);
    row_beat(OP_ADD, 7, 32'd1, 1, 0, 1);
    row_beat(OP_ADD, 6, 32'd1, 0, 0, 0);
    // grow again: the upper node missed the last add
    row_cfg(1024);
    row_beat(OP_QUERY, 1024, '0, 0, 0, 0);
    // zero size: only an empty query is in range
    row_cfg(0);
    row_beat(OP_ADD, 0, 32'd9, 1, 0, 1);
    row_beat(OP_QUERY, 0, '0, 1, 0, 0);
    row_beat(OP_QUERY, 1, '0, 1, 0, 1);
    // oversized register saturates to the full tree
    row_cfg(2047);
    row_beat(OP_ADD, 1023, -32'sd5, 0, 0, 0);
    row_beat(OP_ADD, 1024, 32'd3, 1, 0, 1);
    row_beat(OP_QUERY, 1024, '0, 0, 0, 0);
    row_beat(OP_QUERY, 1025, '0, 1, 0, 1);

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_size(plan[i].cfg_val);
      end else begin
        send_beat(plan[i].beat, plan[i].pinned, plan[i].want);
      end
    end

    // Random phases over several sizes and idling patterns
    for (ph = 0; ph < 9; ph++) begin
      drain_results();
      write_size(POS_W'(sizes[ph]));
      eff = (sizes[ph] > MAX_SIZE) ? MAX_SIZE : sizes[ph];
      case (ph / 3)
        0: begin tx_idle_pct = 14; rx_idle_pct = 86; end
        1: begin tx_idle_pct = 86; rx_idle_pct = 14; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      for (k = 0; k < 60; k++) begin
        // long receiver hold-off while beats keep coming
        if (ph == 6 && k == 8) hold_req++;
        // sender pause until everything is back
        if (ph == 4 && k == 30) drain_results();

        r = $urandom_range(0, 99);
        if (r < 46) b.opcode = OP_ADD;
        else if (r < 94) b.opcode = OP_QUERY;
        else if (r < 97) b.opcode = OP_CLEAR;
        else b.opcode = OP_UNUSED;

        r = $urandom_range(0, 99);
        if (r < 80) b.position = POS_W'($urandom_range(0, eff));
        else if (r < 92) b.position = POS_W'(eff + $urandom_range(0, 2) - 1);
        else b.position = POS_W'($urandom());

        case ($urandom_range(0, 9))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = VAL_W'($urandom_range(0, 20)) - VAL_W'(10);
          default: v = $urandom();
        endcase
        b.add_value = v;

        send_beat(b, 1'b0, '0);
      end
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(100_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
